// ----- rtl/core/brf_pkg.sv -----
// brf_pkg: shared widths, operation codes and status codes for the byte ring FIFO.
// No dependencies; used by brf_adv, brf_ctrl, byte_ring_fifo and brf_checker.
`timescale 1ns / 1ps

package brf_pkg;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t FUNC_PUSH    = 3'd0;
    localparam func_t FUNC_POP     = 3'd1;
    localparam func_t FUNC_PEEK    = 3'd2;
    localparam func_t FUNC_DISCARD = 3'd3;
    localparam func_t FUNC_CLEAR   = 3'd4;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_FULL     = 2'd1;
    localparam status_t STATUS_TOO_LONG = 2'd2;

endpackage

// ----- rtl/core/brf_ram.sv -----
// brf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/brf_adv.sv -----
// brf_adv: shared pointer advance unit, base plus step modulo DEPTH.
// Depends on brf_pkg for the count width.
`timescale 1ns / 1ps

module brf_adv #(
    parameter int DEPTH = 1024
) (
    input  logic [$clog2(DEPTH)-1:0]  base,
    input  logic [brf_pkg::COUNT_W-1:0] step,
    output logic [$clog2(DEPTH)-1:0]  sum
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int SUM_W = ((PTR_W > brf_pkg::COUNT_W) ? PTR_W : brf_pkg::COUNT_W) + 1;

    logic [SUM_W-1:0] raw;
    logic [SUM_W-1:0] wrapped;

    // step never exceeds DEPTH, so one subtract covers the wrap
    assign raw     = SUM_W'(base) + SUM_W'(step);
    assign wrapped = (raw >= SUM_W'(DEPTH)) ? (raw - SUM_W'(DEPTH)) : raw;
    assign sum     = PTR_W'(wrapped);

endmodule

// ----- rtl/core/brf_ctrl.sv -----
// brf_ctrl: operation sequencer, pointers, fill count and output register.
// Depends on brf_pkg and brf_adv; drives the store through brf_ram ports.
`timescale 1ns / 1ps

module brf_ctrl #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  brf_pkg::func_t                func,
    input  logic [brf_pkg::DATA_W-1:0]    data_in,
    input  logic [brf_pkg::COUNT_W-1:0]   byte_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [brf_pkg::DATA_W-1:0]    data_out,
    output logic                          data_valid,
    output brf_pkg::status_t              status,
    output logic                          last,
    output logic [$clog2(DEPTH+1)-1:0]    occupancy,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [brf_pkg::DATA_W-1:0]    ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [brf_pkg::DATA_W-1:0]    ram_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH+1);
    localparam int CW    = brf_pkg::COUNT_W;
    localparam int CMP_W = (OCC_W > CW) ? OCC_W : CW;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_ISSUE = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    brf_pkg::func_t             func_reg, func_next;
    logic [brf_pkg::DATA_W-1:0] data_reg, data_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              remain_reg, remain_next;
    logic [PTR_W-1:0]           addr_reg, addr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [OCC_W-1:0]           fill_reg, fill_next;

    logic                       out_valid_reg, out_valid_next;
    logic [brf_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic                       out_dv_reg, out_dv_next;
    brf_pkg::status_t           out_status_reg, out_status_next;
    logic                       out_last_reg, out_last_next;
    logic [OCC_W-1:0]           out_occ_reg, out_occ_next;

    logic             out_free;
    logic             load;
    logic [PTR_W-1:0] adv_base;
    logic [CW-1:0]    adv_step;
    logic [PTR_W-1:0] adv_sum;
    logic             is_full;
    logic             too_long;
    logic [CW-1:0]    discard_n;

    brf_adv #(.DEPTH(DEPTH)) u_adv (
        .base (adv_base),
        .step (adv_step),
        .sum  (adv_sum)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign is_full   = (fill_reg == OCC_W'(DEPTH));
    assign too_long  = (CMP_W'(count_reg) > CMP_W'(fill_reg))
                    || (count_reg > CW'(MAX_BURST));
    assign discard_n = (CMP_W'(count_reg) > CMP_W'(fill_reg)) ? CW'(fill_reg) : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        data_next       = data_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        addr_next       = addr_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_next       = fill_reg;
        load            = 1'b0;
        out_data_next   = '0;
        out_dv_next     = 1'b0;
        out_status_next = brf_pkg::STATUS_OK;
        out_last_next   = 1'b1;
        adv_base        = rd_ptr_reg;
        adv_step        = count_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg;
        ram_wdata       = data_reg;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    data_next  = data_in;
                    count_next = byte_count;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    unique case (func_reg) inside
                        brf_pkg::FUNC_PUSH:
                        begin
                            if (is_full)
                            begin
                                out_status_next = brf_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                adv_base    = wr_ptr_reg;
                                adv_step    = CW'(1);
                                wr_ptr_next = adv_sum;
                                fill_next   = fill_reg + OCC_W'(1);
                            end
                        end
                        brf_pkg::FUNC_POP, brf_pkg::FUNC_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = brf_pkg::STATUS_OK;
                            end
                            else if (too_long)
                            begin
                                out_status_next = brf_pkg::STATUS_TOO_LONG;
                            end
                            else
                            begin
                                load        = 1'b0;
                                state_next  = S_ISSUE;
                                addr_next   = rd_ptr_reg;
                                remain_next = count_reg;
                                if (func_reg == brf_pkg::FUNC_POP)
                                begin
                                    rd_ptr_next = adv_sum;
                                    fill_next   = fill_reg - OCC_W'(count_reg);
                                end
                            end
                        end
                        brf_pkg::FUNC_DISCARD:
                        begin
                            adv_step    = discard_n;
                            rd_ptr_next = adv_sum;
                            fill_next   = fill_reg - OCC_W'(discard_n);
                        end
                        brf_pkg::FUNC_CLEAR:
                        begin
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            fill_next   = '0;
                        end
                        default:
                        begin
                            out_status_next = brf_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_data_next = ram_rdata;
                    out_dv_next   = 1'b1;
                    out_last_next = (remain_reg == CW'(1));
                    remain_next   = remain_reg - CW'(1);
                    adv_base      = addr_reg;
                    adv_step      = CW'(1);
                    addr_next     = adv_sum;
                    state_next    = (remain_reg == CW'(1)) ? S_IDLE : S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_occ_next = fill_next;
    end

    assign out_valid_next = load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        data_reg   <= data_next;
        count_reg  <= count_next;
        remain_reg <= remain_next;
        addr_reg   <= addr_next;
        if (load)
        begin
            out_data_reg   <= out_data_next;
            out_dv_reg     <= out_dv_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign data_out   = out_data_reg;
    assign data_valid = out_dv_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;
    assign occupancy  = out_occ_reg;

endmodule

// ----- rtl/core/byte_ring_fifo.sv -----
// byte_ring_fifo: circular byte FIFO with push, pop, peek, discard and clear.
// Depends on brf_pkg, brf_ram, brf_adv and brf_ctrl.
// Push, discard, clear: input stalls until the execute state registers the result.
// Pop/peek of n bytes: each byte passes a RAM read state, then an emit state.
// Reset (rst_n low, async): pointers and fill count zero, no transaction pending.
`timescale 1ns / 1ps

module byte_ring_fifo #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [brf_pkg::FUNC_W-1:0]    func,
    input  logic [brf_pkg::DATA_W-1:0]    data_in,
    input  logic [brf_pkg::COUNT_W-1:0]   byte_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [brf_pkg::DATA_W-1:0]    data_out,
    output logic                          data_valid,
    output logic [brf_pkg::STATUS_W-1:0]  status,
    output logic                          last,
    output logic [$clog2(DEPTH+1)-1:0]    occupancy
);

    localparam int PTR_W = $clog2(DEPTH);

    logic                       ram_we;
    logic [PTR_W-1:0]           ram_waddr;
    logic [brf_pkg::DATA_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [PTR_W-1:0]           ram_raddr;
    logic [brf_pkg::DATA_W-1:0] ram_rdata;

    brf_ram #(
        .WIDTH (brf_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brf_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .data_in    (data_in),
        .byte_count (byte_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_out   (data_out),
        .data_valid (data_valid),
        .status     (status),
        .last       (last),
        .occupancy  (occupancy),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

endmodule

// ----- rtl/core/brf_checker.sv -----
// brf_checker: port-level assertions for byte_ring_fifo, attached by bind.
// Depends on brf_pkg and the byte_ring_fifo ports.
`timescale 1ns / 1ps

module brf_checker #(
    parameter int DEPTH = 1024
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [brf_pkg::DATA_W-1:0]    data_out,
    input logic                          data_valid,
    input logic [brf_pkg::STATUS_W-1:0]  status,
    input logic                          last,
    input logic [$clog2(DEPTH+1)-1:0]    occupancy
);

    // one operation at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while operation in flight");

    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !data_valid) |-> (data_out == '0))
        else $error("data_out nonzero without data_valid");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != brf_pkg::STATUS_OK)) |-> (last && !data_valid))
        else $error("error status on a data or non-final transaction");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= ($clog2(DEPTH+1))'(DEPTH)))
        else $error("occupancy above depth");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(data_out) && $stable(last)))
        else $error("stalled output transaction changed");

endmodule

bind byte_ring_fifo brf_checker #(.DEPTH(DEPTH)) u_brf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .data_valid (data_valid),
    .status     (status),
    .last       (last),
    .occupancy  (occupancy)
);
